### sv/tdm_pkg.sv
// ----------------------------------------------------------------------------
// tdm_pkg
// Shared types, constants and the exponential curve table of the tank drive
// mixer.
// ----------------------------------------------------------------------------
package tdm_pkg;

    // pulse width that maps to full forward; 1060 us maps to full reverse,
    // so the slope is 510/816 = 5/8 per microsecond
    localparam int PULSE_AT_FULL = 1876;
    localparam int STICK_MAX     = 255;
    localparam int CURVE_LAST    = 224;

    localparam logic [7:0] SPEED_DZ_RESET = 8'd25;
    localparam logic [7:0] STEER_DZ_RESET = 8'd25;
    localparam logic [7:0] TRACK_DZ_RESET = 8'd1;

    typedef enum logic [1:0] {
        REG_SPEED_DZ = 2'd0,
        REG_STEER_DZ = 2'd1,
        REG_TRACK_DZ = 2'd2
    } cfg_reg_t;

    typedef logic signed [9:0]  stick_val_t;   // -255..255
    typedef logic signed [10:0] mix_val_t;     // -510..510
    typedef logic signed [8:0]  curve_val_t;   // -255..255

    typedef struct packed {
        stick_val_t speed;
        stick_val_t steer;
        logic [7:0] preload;
    } stick_t;

    typedef struct packed {
        mix_val_t   left;
        mix_val_t   right;
        logic [7:0] preload;
    } mix_t;

    typedef struct packed {
        logic       fwd;
        logic       rev;
        logic [7:0] duty;
    } track_t;

    // floor(2^(1 + a/32)) for a = 0..224
    localparam logic [8:0] CURVE_ROM [CURVE_LAST+1] = '{
        9'd2, 9'd2, 9'd2, 9'd2, 9'd2, 9'd2, 9'd2, 9'd2,
        9'd2, 9'd2, 9'd2, 9'd2, 9'd2, 9'd2, 9'd2, 9'd2,
        9'd2, 9'd2, 9'd2, 9'd3, 9'd3, 9'd3, 9'd3, 9'd3,
        9'd3, 9'd3, 9'd3, 9'd3, 9'd3, 9'd3, 9'd3, 9'd3,
        9'd4, 9'd4, 9'd4, 9'd4, 9'd4, 9'd4, 9'd4, 9'd4,
        9'd4, 9'd4, 9'd4, 9'd5, 9'd5, 9'd5, 9'd5, 9'd5,
        9'd5, 9'd5, 9'd5, 9'd6, 9'd6, 9'd6, 9'd6, 9'd6,
        9'd6, 9'd6, 9'd7, 9'd7, 9'd7, 9'd7, 9'd7, 9'd7,
        9'd8, 9'd8, 9'd8, 9'd8, 9'd8, 9'd8, 9'd9, 9'd9,
        9'd9, 9'd9, 9'd9, 9'd10, 9'd10, 9'd10, 9'd10, 9'd11,
        9'd11, 9'd11, 9'd11, 9'd12, 9'd12, 9'd12, 9'd12, 9'd13,
        9'd13, 9'd13, 9'd14, 9'd14, 9'd14, 9'd14, 9'd15, 9'd15,
        9'd16, 9'd16, 9'd16, 9'd17, 9'd17, 9'd17, 9'd18, 9'd18,
        9'd19, 9'd19, 9'd19, 9'd20, 9'd20, 9'd21, 9'd21, 9'd22,
        9'd22, 9'd23, 9'd23, 9'd24, 9'd24, 9'd25, 9'd25, 9'd26,
        9'd26, 9'd27, 9'd28, 9'd28, 9'd29, 9'd29, 9'd30, 9'd31,
        9'd32, 9'd32, 9'd33, 9'd34, 9'd34, 9'd35, 9'd36, 9'd37,
        9'd38, 9'd38, 9'd39, 9'd40, 9'd41, 9'd42, 9'd43, 9'd44,
        9'd45, 9'd46, 9'd47, 9'd48, 9'd49, 9'd50, 9'd51, 9'd52,
        9'd53, 9'd54, 9'd56, 9'd57, 9'd58, 9'd59, 9'd61, 9'd62,
        9'd64, 9'd65, 9'd66, 9'd68, 9'd69, 9'd71, 9'd72, 9'd74,
        9'd76, 9'd77, 9'd79, 9'd81, 9'd82, 9'd84, 9'd86, 9'd88,
        9'd90, 9'd92, 9'd94, 9'd96, 9'd98, 9'd100, 9'd103, 9'd105,
        9'd107, 9'd109, 9'd112, 9'd114, 9'd117, 9'd119, 9'd122, 9'd125,
        9'd128, 9'd130, 9'd133, 9'd136, 9'd139, 9'd142, 9'd145, 9'd148,
        9'd152, 9'd155, 9'd158, 9'd162, 9'd165, 9'd169, 9'd173, 9'd177,
        9'd181, 9'd184, 9'd189, 9'd193, 9'd197, 9'd201, 9'd206, 9'd210,
        9'd215, 9'd219, 9'd224, 9'd229, 9'd234, 9'd239, 9'd245, 9'd250,
        9'd256
    };

endpackage

### sv/tdm_scale.sv
// ----------------------------------------------------------------------------
// tdm_scale
// Two-stage pulse scaler: maps speed, steer and knob pulse widths onto
// +-255 with truncation toward zero and derives the duty preload.
// ----------------------------------------------------------------------------
module tdm_scale #(
    parameter int PULSE_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [PULSE_BITS-1:0] speed_pulse,
    input  logic [PULSE_BITS-1:0] steer_pulse,
    input  logic [PULSE_BITS-1:0] knob_pulse,
    output logic                  out_valid,
    output tdm_pkg::stick_t       stick
);
    import tdm_pkg::*;

    localparam int DW = PULSE_BITS + 1;
    localparam int PW = PULSE_BITS + 4;
    localparam logic signed [DW-1:0] OFFSET = DW'(PULSE_AT_FULL);
    localparam logic signed [PW-1:0] Q_LOW  = PW'(-2 * STICK_MAX);

    // 5 * (pulse - 1876)
    function automatic logic signed [PW-1:0] times5(input logic [PULSE_BITS-1:0] p);
        logic signed [DW-1:0] d;
        d = $signed({1'b0, p}) - OFFSET;
        return (PW'(d) <<< 2) + PW'(d);
    endfunction

    // truncating divide by 8, then clamp so that q + 255 lands in +-255
    function automatic stick_val_t clamp_q(input logic signed [PW-1:0] m);
        logic signed [PW-1:0] q;
        q = (m + (m[PW-1] ? PW'(7) : PW'(0))) >>> 3;
        if (q > 0)
        begin
            q = '0;
        end
        else if (q < Q_LOW)
        begin
            q = Q_LOW;
        end
        return q[9:0];
    endfunction

    logic signed [PW-1:0] speed_m_reg;
    logic signed [PW-1:0] steer_m_reg;
    logic signed [PW-1:0] knob_m_reg;
    logic                 vld1_reg;
    logic                 vld2_reg;
    stick_t               stick_reg;
    stick_t               stick_next;
    stick_val_t           speed_q;
    stick_val_t           steer_q;
    stick_val_t           knob_q;
    logic [9:0]           pre_sum;

    always_ff @(posedge clk)
    begin
        speed_m_reg <= times5(speed_pulse);
        steer_m_reg <= times5(steer_pulse);
        knob_m_reg  <= times5(knob_pulse);
    end

    always_comb
    begin
        speed_q = clamp_q(speed_m_reg);
        steer_q = clamp_q(steer_m_reg);
        knob_q  = clamp_q(knob_m_reg);
        // knob runs inverted: knob + 257 = 2 - q, in 2..512
        pre_sum = $unsigned(10'sd2 - knob_q);
        stick_next.speed   = speed_q + 10'sd255;
        stick_next.steer   = steer_q + 10'sd255;
        stick_next.preload = pre_sum[9:2];
    end

    always_ff @(posedge clk)
    begin
        stick_reg <= stick_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= in_valid;
            vld2_reg <= vld1_reg;
        end
    end

    assign out_valid = vld2_reg;
    assign stick     = stick_reg;

endmodule

### sv/tdm_mix.sv
// ----------------------------------------------------------------------------
// tdm_mix
// Two-stage stick deadzone and arcade mixer: left = speed + steer,
// right = speed - steer, each limited to the speed on the speed's side.
// ----------------------------------------------------------------------------
module tdm_mix (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  tdm_pkg::stick_t stick,
    input  logic [7:0]      speed_dz,
    input  logic [7:0]      steer_dz,
    output logic            out_valid,
    output tdm_pkg::mix_t   mix
);
    import tdm_pkg::*;

    // deadzone that also pulls the outside band in by its width
    function automatic stick_val_t dead(input stick_val_t s, input logic [7:0] dz);
        stick_val_t d;
        d = $signed({2'b00, dz});
        if (s < d && s > -d)
        begin
            return '0;
        end
        else if (s < d)
        begin
            return s + d;
        end
        return s - d;
    endfunction

    stick_val_t spd_reg;
    stick_val_t str_reg;
    logic [7:0] pre_reg;
    logic       vld_a_reg;
    logic       vld_b_reg;
    mix_t       mix_reg;
    mix_t       mix_next;
    mix_val_t   sp;

    always_ff @(posedge clk)
    begin
        spd_reg <= dead(stick.speed, speed_dz);
        str_reg <= dead(stick.steer, steer_dz);
        pre_reg <= stick.preload;
    end

    always_comb
    begin
        sp            = mix_val_t'(spd_reg);
        mix_next.left  = sp + mix_val_t'(str_reg);
        mix_next.right = sp - mix_val_t'(str_reg);
        if (sp > 0 && mix_next.left > sp)
        begin
            mix_next.left = sp;
        end
        if (sp > 0 && mix_next.right > sp)
        begin
            mix_next.right = sp;
        end
        if (sp < 0 && mix_next.left < sp)
        begin
            mix_next.left = sp;
        end
        if (sp < 0 && mix_next.right < sp)
        begin
            mix_next.right = sp;
        end
        mix_next.preload = pre_reg;
    end

    always_ff @(posedge clk)
    begin
        mix_reg <= mix_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end
        else
        begin
            vld_a_reg <= in_valid;
            vld_b_reg <= vld_a_reg;
        end
    end

    assign out_valid = vld_b_reg;
    assign mix       = mix_reg;

endmodule

### sv/tdm_track.sv
// ----------------------------------------------------------------------------
// tdm_track
// Three-stage track output: exponential curve, track deadzone and direction,
// duty mapped from 0..255 onto preload..255.
// ----------------------------------------------------------------------------
module tdm_track (
    input  logic              clk,
    input  tdm_pkg::mix_val_t t,
    input  logic [7:0]        preload,
    input  logic [7:0]        track_dz,
    output tdm_pkg::track_t   trk
);
    import tdm_pkg::*;

    // curve stage
    logic [9:0] a;
    logic       big;
    logic [8:0] r;
    logic [9:0] pos_sum;
    logic [9:0] neg_sum;
    curve_val_t cv_next;
    curve_val_t cv_reg;
    logic [7:0] pre_c_reg;

    // deadzone / product stage
    logic signed [9:0] cv10;
    logic signed [9:0] ds;
    logic              off;
    logic              fwd;
    logic              rev;
    logic [7:0]        mag;
    logic [15:0]       prod_reg;
    logic [7:0]        pre_d_reg;
    logic              fwd_reg;
    logic              rev_reg;
    logic              off_reg;

    // divide-by-255 stage
    logic [15:0] div_sum;
    track_t      trk_next;
    track_t      trk_reg;

    always_comb
    begin
        a   = t[10] ? 10'(-t) : 10'(t);
        big = a > 10'(CURVE_LAST);
        r   = big ? 9'd0 : CURVE_ROM[a[7:0]];
        pos_sum = 10'(r) + 10'd2;
        neg_sum = 10'd2 - 10'(r);
        if (t > 0)
        begin
            cv_next = (big || pos_sum > 10'd255) ? 9'sd255 : $signed(pos_sum[8:0]);
        end
        else
        begin
            cv_next = big ? -9'sd255 : $signed(neg_sum[8:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        cv_reg    <= cv_next;
        pre_c_reg <= preload;
    end

    always_comb
    begin
        cv10 = 10'(cv_reg);
        ds   = $signed({2'b00, track_dz});
        off  = cv10 < ds && cv10 > -ds;
        // zero deadzone with zero curve sets neither direction
        fwd  = !off && cv10 > -ds;
        rev  = !off && !fwd && cv10 < ds;
        mag  = cv_reg[8] ? 8'(-cv10) : cv_reg[7:0];
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= 16'(mag) * 16'(8'd255 - pre_c_reg);
        pre_d_reg <= pre_c_reg;
        fwd_reg   <= fwd;
        rev_reg   <= rev;
        off_reg   <= off;
    end

    always_comb
    begin
        // exact x / 255 for x up to 65025
        div_sum       = prod_reg + 16'(prod_reg[15:8]) + 16'd1;
        trk_next.fwd  = fwd_reg;
        trk_next.rev  = rev_reg;
        trk_next.duty = off_reg ? 8'd0 : div_sum[15:8] + pre_d_reg;
    end

    always_ff @(posedge clk)
    begin
        trk_reg <= trk_next;
    end

    assign trk = trk_reg;

endmodule

### sv/tank_drive_mixer.sv
// ----------------------------------------------------------------------------
// tank_drive_mixer
// Arcade stick to tank track mixer with exponential curve and preload duty.
// ----------------------------------------------------------------------------
// Usage:
//   Input word: speed_pulse, steer_pulse, knob_pulse (pulse widths in us),
//   taken on every clock edge with start high; busy is always low, so a new
//   word may be presented every cycle.
//   Result word: left/right forward, reverse and duty, valid for exactly one
//   cycle while done is high. The receiver has no way to hold results off.
//   Pipeline: 2 scale stages, 2 deadzone/mix stages and 3 curve/duty stages
//   lie between the start edge and the done cycle. Throughput: one word per
//   cycle; the pipeline never stalls.
//   Config: cfg_write with cfg_addr 0/1/2 writes speed, steer and track
//   deadzones from cfg_wdata; other addresses are ignored.
//   Write only while no word is in flight.
//   Reset: clears all valid bits (no done for words in flight) and loads
//   deadzones 25, 25 and 1.
// ----------------------------------------------------------------------------
module tank_drive_mixer #(
    parameter int PULSE_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [PULSE_BITS-1:0] speed_pulse,
    input  logic [PULSE_BITS-1:0] steer_pulse,
    input  logic [PULSE_BITS-1:0] knob_pulse,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_addr,
    input  logic [7:0]            cfg_wdata,
    output logic                  done,
    output logic                  left_forward,
    output logic                  left_reverse,
    output logic [7:0]            left_duty,
    output logic                  right_forward,
    output logic                  right_reverse,
    output logic [7:0]            right_duty
);
    import tdm_pkg::*;

    logic [7:0] speed_dz_reg;
    logic [7:0] steer_dz_reg;
    logic [7:0] track_dz_reg;

    logic       scale_vld;
    stick_t     stick;
    logic       mix_vld;
    mix_t       mix;
    logic [2:0] trk_vld_reg;
    track_t     left_trk;
    track_t     right_trk;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_dz_reg <= SPEED_DZ_RESET;
            steer_dz_reg <= STEER_DZ_RESET;
            track_dz_reg <= TRACK_DZ_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_SPEED_DZ: speed_dz_reg <= cfg_wdata;
                REG_STEER_DZ: steer_dz_reg <= cfg_wdata;
                REG_TRACK_DZ: track_dz_reg <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    tdm_scale #(
        .PULSE_BITS (PULSE_BITS)
    ) u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start),
        .speed_pulse (speed_pulse),
        .steer_pulse (steer_pulse),
        .knob_pulse  (knob_pulse),
        .out_valid   (scale_vld),
        .stick       (stick)
    );

    tdm_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (scale_vld),
        .stick     (stick),
        .speed_dz  (speed_dz_reg),
        .steer_dz  (steer_dz_reg),
        .out_valid (mix_vld),
        .mix       (mix)
    );

    tdm_track u_left (
        .clk      (clk),
        .t        (mix.left),
        .preload  (mix.preload),
        .track_dz (track_dz_reg),
        .trk      (left_trk)
    );

    tdm_track u_right (
        .clk      (clk),
        .t        (mix.right),
        .preload  (mix.preload),
        .track_dz (track_dz_reg),
        .trk      (right_trk)
    );

    // valid bits for the three track stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trk_vld_reg <= '0;
        end
        else
        begin
            trk_vld_reg <= {trk_vld_reg[1:0], mix_vld};
        end
    end

    assign busy          = 1'b0;
    assign done          = trk_vld_reg[2];
    assign left_forward  = left_trk.fwd;
    assign left_reverse  = left_trk.rev;
    assign left_duty     = left_trk.duty;
    assign right_forward = right_trk.fwd;
    assign right_reverse = right_trk.rev;
    assign right_duty    = right_trk.duty;

    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##7 done)
        else $error("accepted word did not finish after 7 cycles");

    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 7))
        else $error("done without a word accepted 7 cycles earlier");

    a_dir_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(left_forward && left_reverse) && !(right_forward && right_reverse))
        else $error("track driven forward and reverse at once");

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the tank drive mixer. Words of three pulse widths
// go in through the start/busy handshake. An internal predictor works out
// the direction bits and duty of both tracks. Each done word is checked
// against the oldest pending prediction, over several deadzone settings and
// sender idle patterns.
// ----------------------------------------------------------------------------
module testbench;
    import tdm_pkg::*;

    localparam int PULSE_BITS   = 12;
    localparam int PULSE_AT_REV = 1060;
    localparam int PIPE_LATENCY = 7;
    localparam int STALL_LIMIT  = 2000;
    localparam int MAX_REPORTS  = 10;
    localparam int CURVE_SAT    = 512;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        track_t left;
        track_t right;
    } drive_t;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  start       = 1'b0;
    logic [PULSE_BITS-1:0] speed_pulse = '0;
    logic [PULSE_BITS-1:0] steer_pulse = '0;
    logic [PULSE_BITS-1:0] knob_pulse  = '0;
    logic                  cfg_write   = 1'b0;
    logic [1:0]            cfg_addr    = '0;
    logic [7:0]            cfg_wdata   = '0;

    wire       busy;
    wire       done;
    wire       left_forward;
    wire       left_reverse;
    wire [7:0] left_duty;
    wire       right_forward;
    wire       right_reverse;
    wire [7:0] right_duty;

    // predictor copy of the deadzone registers
    logic [7:0] dz_speed = SPEED_DZ_RESET;
    logic [7:0] dz_steer = STEER_DZ_RESET;
    logic [7:0] dz_track = TRACK_DZ_RESET;

    drive_t pending_drive[$];
    int     errors          = 0;
    int     idle_cycles     = 0;
    int     sender_idle_pct = 0;

    tank_drive_mixer #(
        .PULSE_BITS(PULSE_BITS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .speed_pulse  (speed_pulse),
        .steer_pulse  (steer_pulse),
        .knob_pulse   (knob_pulse),
        .cfg_write    (cfg_write),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .done         (done),
        .left_forward (left_forward),
        .left_reverse (left_reverse),
        .left_duty    (left_duty),
        .right_forward(right_forward),
        .right_reverse(right_reverse),
        .right_duty   (right_duty)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------- predictor ----------------

    function automatic int clamp_stick(int v);
        if (v > STICK_MAX)
            return STICK_MAX;
        if (v < -STICK_MAX)
            return -STICK_MAX;
        return v;
    endfunction

    // linear map, full_fwd at 1876 us and -full_fwd at 1060 us, truncating
    function automatic int pulse_to_stick(int p, int full_fwd);
        return clamp_stick((p - PULSE_AT_FULL) * (-2 * full_fwd)
                           / (PULSE_AT_REV - PULSE_AT_FULL) + full_fwd);
    endfunction

    function automatic int strip_deadzone(int s, int dz);
        if (s < dz && s > -dz)
            return 0;
        if (s < dz)
            return s + dz;
        return s - dz;
    endfunction

    // 2 + floor(2^(1+t/32)) above zero, 2 - floor(2^(1+|t|/32)) otherwise, clamped to +-255
    function automatic int exp_curve(int t);
        int mag;
        int base;
        mag = (t > 0) ? t : -t;
        if (mag > CURVE_LAST)
            base = CURVE_SAT;
        else
            base = int'($floor(2.0 ** (1.0 + mag / 32.0) + 1.0e-9));
        return clamp_stick((t > 0) ? 2 + base : 2 - base);
    endfunction

    function automatic track_t track_drive(int c, int preload);
        track_t o;
        int     d;
        int     mag;
        int     duty_full;
        o = '0;
        d = int'(dz_track);
        if (c < d && c > -d)
            return o;
        if (c > -d)
            o.fwd = 1'b1;
        else if (c < d)
            o.rev = 1'b1;
        mag = (c < 0) ? -c : c;
        duty_full = (mag * (STICK_MAX - preload)) / STICK_MAX + preload;
        o.duty = duty_full[7:0];
        return o;
    endfunction

    function automatic drive_t predict_drive(int sp, int st, int kn);
        drive_t r;
        int     speed;
        int     steer;
        int     preload;
        int     left;
        int     right;
        speed   = strip_deadzone(pulse_to_stick(sp, STICK_MAX), int'(dz_speed));
        steer   = strip_deadzone(pulse_to_stick(st, STICK_MAX), int'(dz_steer));
        preload = (pulse_to_stick(kn, -STICK_MAX) + 257) / 4;
        left    = speed + steer;
        right   = speed - steer;
        // each track is held to the speed magnitude on the speed's side
        if (speed > 0 && left > speed)
            left = speed;
        if (speed > 0 && right > speed)
            right = speed;
        if (speed < 0 && left < speed)
            left = speed;
        if (speed < 0 && right < speed)
            right = speed;
        r.left  = track_drive(exp_curve(left), preload);
        r.right = track_drive(exp_curve(right), preload);
        return r;
    endfunction

    // ---------------- driving ----------------

    task automatic send_word(input logic [PULSE_BITS-1:0] sp,
                             input logic [PULSE_BITS-1:0] st,
                             input logic [PULSE_BITS-1:0] kn);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        speed_pulse <= sp;
        steer_pulse <= st;
        knob_pulse  <= kn;
        do
            @(posedge clk);
        while (busy);
        pending_drive.push_back(predict_drive(int'(sp), int'(st), int'(kn)));
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_drive.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] addr, input logic [7:0] data);
        drain();
        cfg_write <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (addr)
            REG_SPEED_DZ: dz_speed = data;
            REG_STEER_DZ: dz_steer = data;
            REG_TRACK_DZ: dz_track = data;
            default: ;
        endcase
        @(posedge clk);
    endtask

    function automatic logic [PULSE_BITS-1:0] rand_pulse();
        int p;
        case ($urandom_range(9))
            0, 1:    p = $urandom_range(4095);
            2:       p = $urandom_range(1)
                         ? $urandom_range(PULSE_AT_REV - 20, PULSE_AT_REV + 20)
                         : $urandom_range(PULSE_AT_FULL - 20, PULSE_AT_FULL + 20);
            default: p = $urandom_range(1000, 1950);
        endcase
        return PULSE_BITS'(p);
    endfunction

    // ---------------- tests ----------------

    task automatic test_reset_defaults();
        sender_idle_pct = 0;
        send_word(12'd1468, 12'd1468, 12'd1468);   // sticks centered
        send_word(12'd1876, 12'd1468, 12'd1060);   // full forward, top preload
        send_word(12'd1060, 12'd1468, 12'd1876);   // full reverse, zero preload
        send_word(12'd1468, 12'd1876, 12'd1468);   // spin in place
        send_word(12'd1468, 12'd1060, 12'd1468);
        send_word(12'd1876, 12'd1876, 12'd1500);   // limit to speed magnitude
        send_word(12'd1060, 12'd1060, 12'd1500);
        send_word(12'd1700, 12'd1300, 12'd1200);
        send_word(12'd1490, 12'd1450, 12'd1468);   // inside stick deadzones
        send_word(12'd1230, 12'd1700, 12'd1700);
        send_word(12'd0,    12'd0,    12'd0);      // no frame
        send_word(12'd4095, 12'd4095, 12'd4095);
        send_word(12'd4095, 12'd0,    12'd2048);
    endtask

    task automatic test_zero_deadzones();
        write_reg(REG_SPEED_DZ, 8'd0);
        write_reg(REG_STEER_DZ, 8'd0);
        write_reg(REG_TRACK_DZ, 8'd0);
        send_word(12'd1468, 12'd1468, 12'd1468);   // curved zero, duty = preload
        send_word(12'd1466, 12'd1468, 12'd2000);   // small reverse curves to zero
        send_word(12'd1470, 12'd1466, 12'd1468);
        send_word(12'd1876, 12'd1060, 12'd0);
        send_word(12'd1060, 12'd1876, 12'd4095);
    endtask

    task automatic test_max_deadzones();
        write_reg(REG_SPEED_DZ, 8'd255);
        write_reg(REG_STEER_DZ, 8'd255);
        write_reg(REG_TRACK_DZ, 8'd255);
        send_word(12'd1876, 12'd1060, 12'd1468);   // sticks fully swallowed
        send_word(12'd4095, 12'd0,    12'd1060);
        write_reg(REG_SPEED_DZ, 8'd0);
        write_reg(REG_STEER_DZ, 8'd0);
        send_word(12'd1876, 12'd1468, 12'd1468);   // only saturated tracks run
        send_word(12'd1060, 12'd1468, 12'd1060);
        send_word(12'd1700, 12'd1468, 12'd1468);   // stopped track
    endtask

    task automatic test_unused_index();
        write_reg(REG_SPEED_DZ, 8'd10);
        write_reg(REG_STEER_DZ, 8'd40);
        write_reg(REG_TRACK_DZ, 8'd5);
        write_reg(REG_UNUSED, 8'($urandom_range(255)));
        send_word(12'd1520, 12'd1400, 12'd1468);
        send_word(12'd1468, 12'd1540, 12'd1300);
        send_word(12'd1400, 12'd1468, 12'd1100);
    endtask

    task automatic test_random_traffic();
        int idle_pattern[3];
        idle_pattern = '{0, 77, 22};
        for (int phase = 0; phase < 6; phase++)
        begin
            // mostly small deadzones so the sticks stay live
            if (phase == 5)
            begin
                write_reg(REG_SPEED_DZ, 8'($urandom_range(255)));
                write_reg(REG_STEER_DZ, 8'($urandom_range(255)));
                write_reg(REG_TRACK_DZ, 8'($urandom_range(255)));
            end
            else
            begin
                write_reg(REG_SPEED_DZ, 8'($urandom_range(40)));
                write_reg(REG_STEER_DZ, 8'($urandom_range(40)));
                write_reg(REG_TRACK_DZ, 8'($urandom_range(12)));
            end
            sender_idle_pct = idle_pattern[phase % 3];
            for (int i = 0; i < 65; i++)
                send_word(rand_pulse(), rand_pulse(), rand_pulse());
        end
        sender_idle_pct = 0;
    endtask

    // ---------------- checking ----------------

    always @(posedge clk)
    begin : check_results
        drive_t got;
        drive_t want;
        if (rst_n && done)
        begin
            got = {left_forward, left_reverse, left_duty,
                   right_forward, right_reverse, right_duty};
            if (pending_drive.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result word %h", $realtime, got);
            end
            else
            begin
                want = pending_drive.pop_front();
                if (got.left.fwd !== want.left.fwd || got.left.rev !== want.left.rev ||
                    got.left.duty !== want.left.duty ||
                    got.right.fwd !== want.right.fwd || got.right.rev !== want.right.rev ||
                    got.right.duty !== want.right.duty)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display({"%0t: mismatch L fwd/rev/duty exp %b/%b/%0d ",
                                  "got %b/%b/%0d, R exp %b/%b/%0d got %b/%b/%0d"},
                                 $realtime,
                                 want.left.fwd, want.left.rev, want.left.duty,
                                 got.left.fwd, got.left.rev, got.left.duty,
                                 want.right.fwd, want.right.rev, want.right.duty,
                                 got.right.fwd, got.right.rev, got.right.duty);
                end
            end
        end
    end

    // ends the run if no word moves either way for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_zero_deadzones();
        test_max_deadzones();
        test_unused_index();
        test_random_traffic();
        drain();
        repeat (PIPE_LATENCY + 3) @(posedge clk);
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
